/* design/kth_order_select_assert.svh */
// Assertion macros used by the checker file
`ifndef KTH_ORDER_SELECT_ASSERT_SVH
`define KTH_ORDER_SELECT_ASSERT_SVH
// implication checked every clock outside reset
`define KOS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define KOS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/kos_pkg.sv */
// ----------------------------------------------------------------------------
// kos_pkg
// Shared constants and types for the k-th order select block.
// ----------------------------------------------------------------------------
package kos_pkg;
  localparam int MAX_ITEMS_DEF  = 1024;
  localparam int NAME_BYTES_DEF = 8;
  localparam int STEP_W   = 31;
  localparam int NAME_W   = 64;
  localparam int QIDX_W   = 10;
  localparam int IN_DATA_W  = 112;  // 31+64+10 -> 105, padded to 14 bytes
  localparam int OUT_DATA_W = 96;   // 31+64 -> 95, padded to 12 bytes

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_IDX  = 2'd1,
    ST_FULL = 2'd2,
    ST_RSV  = 2'd3
  } status_t;

  // descending order: a strictly before b
  function automatic logic ranks_before(input logic [STEP_W-1:0] sa,
                                        input logic [NAME_W-1:0] na,
                                        input logic [STEP_W-1:0] sb,
                                        input logic [NAME_W-1:0] nb);
    ranks_before = (sa != sb) ? (sa > sb) : (na > nb);
  endfunction
endpackage

/* design/kos_store.sv */
// ----------------------------------------------------------------------------
// kos_store
// Record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kos_store #(
  parameter int MAX_ITEMS = kos_pkg::MAX_ITEMS_DEF,
  parameter int AW = $clog2(MAX_ITEMS)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [kos_pkg::STEP_W-1:0] wr_steps,
  input  logic [kos_pkg::NAME_W-1:0] wr_name,
  input  logic [AW-1:0]             rd_addr,
  output logic [kos_pkg::STEP_W-1:0] rd_steps,
  output logic [kos_pkg::NAME_W-1:0] rd_name
);
  import kos_pkg::*;

  logic [STEP_W+NAME_W-1:0] mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_steps, wr_name};
    end
    {rd_steps, rd_name} <= mem[rd_addr];
  end
endmodule

/* design/kth_order_select.sv */
// ----------------------------------------------------------------------------
// kth_order_select
// Record store answering descending-rank queries.
// ----------------------------------------------------------------------------
// channel | dir | content
// in_     | in  | action (tuser), step_count, item_name_key, query_index
// out_    | out | found_steps, found_name_key, status (tuser)
// Append, index beyond count: result valid the cycle after the accept.
// Query with n stored records: candidates are tried in order from record 0
// until one matches; per candidate one read, one capture and a scan reading
// all n records, set by the single memory read port.
// Clear and unused action: no result. Reset is synchronous; state and
// count reset, the memory does not. Input stalls while a result waits or a
// query runs.
module kth_order_select #(
  parameter int MAX_ITEMS  = kos_pkg::MAX_ITEMS_DEF,
  parameter int NAME_BYTES = kos_pkg::NAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // step_count[30:0], item_name_key[94:31], query_index[104:95], zero pad
  input  logic [kos_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // found_steps[30:0], found_name_key[94:31], zero pad
  output logic [kos_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                    out_tuser
);
  import kos_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = AW + 1;
  // width that holds both a query index and the count
  localparam int XW = (CW > QIDX_W) ? CW : QIDX_W;
  localparam logic [NAME_W-1:0] NAME_MASK = ~(NAME_W'(0)) << (NAME_W - 8*NAME_BYTES);

  typedef enum logic [2:0] {S_IDLE, S_CAND, S_CAND_W, S_SCAN, S_OUT} state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     i_r, j_r, qk_r;
  logic [CW-1:0]     above_r, same_r;
  logic [STEP_W-1:0] cs_r, os_r;
  logic [NAME_W-1:0] cn_r, on_r;
  status_t           ost_r;
  logic              last_r;  // scan read issued for final j

  logic [AW-1:0]     rd_addr;
  logic [STEP_W-1:0] rd_steps;
  logic [NAME_W-1:0] rd_name;
  logic              wr_en;

  logic [STEP_W-1:0] in_steps;
  logic [NAME_W-1:0] in_name;
  logic [QIDX_W-1:0] in_qidx;
  action_t           in_act;

  assign in_steps = in_tdata[STEP_W-1:0];
  assign in_name  = in_tdata[STEP_W+NAME_W-1:STEP_W];
  assign in_qidx  = in_tdata[STEP_W+NAME_W+QIDX_W-1:STEP_W+NAME_W];
  assign in_act   = action_t'(in_tuser);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {{(OUT_DATA_W-STEP_W-NAME_W){1'b0}}, on_r, os_r};
  assign out_tuser  = ost_r;

  assign wr_en = in_tvalid && in_tready && (in_act == ACT_APPEND)
                 && (count_r < CW'(MAX_ITEMS));

  always_comb begin
    if (state_r == S_IDLE || state_r == S_CAND) rd_addr = i_r;
    else rd_addr = j_r;
  end

  kos_store #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(count_r[AW-1:0]),
    .wr_steps(in_steps), .wr_name(in_name & NAME_MASK),
    .rd_addr(rd_addr), .rd_steps(rd_steps), .rd_name(rd_name)
  );

  logic [CW-1:0] above_nxt, same_nxt;
  logic          rb, eq;
  always_comb begin
    rb = ranks_before(rd_steps, rd_name, cs_r, cn_r);
    eq = (rd_steps == cs_r) && (rd_name == cn_r);
    above_nxt = above_r + CW'(rb);
    same_nxt  = same_r + CW'(!rb && eq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            os_r <= '0;
            on_r <= '0;
            unique case (in_act)
              ACT_APPEND: begin
                if (count_r < CW'(MAX_ITEMS)) begin
                  count_r <= count_r + CW'(1);
                  ost_r   <= ST_OK;
                end else begin
                  ost_r <= ST_FULL;
                end
                state_r <= S_OUT;
              end
              ACT_QUERY: begin
                if (XW'(in_qidx) >= XW'(count_r)) begin
                  ost_r   <= ST_IDX;
                  state_r <= S_OUT;
                end else begin
                  qk_r    <= AW'(in_qidx);
                  i_r     <= '0;
                  state_r <= S_CAND;
                end
              end
              ACT_CLEAR: count_r <= '0;
              default: ;
            endcase
          end
        end
        S_CAND: state_r <= S_CAND_W;  // read of candidate i issued
        S_CAND_W: begin
          cs_r    <= rd_steps;
          cn_r    <= rd_name;
          above_r <= '0;
          same_r  <= '0;
          j_r     <= '0;
          last_r  <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // issue read j; data of previous read arrives each cycle after first
          if (j_r != '0 || last_r) begin
            above_r <= above_nxt;
            same_r  <= same_nxt;
          end
          if (last_r) begin
            if (above_nxt <= CW'(qk_r) && CW'(qk_r) < above_nxt + same_nxt) begin
              os_r    <= cs_r;
              on_r    <= cn_r;
              ost_r   <= ST_OK;
              state_r <= S_OUT;
            end else begin
              i_r     <= i_r + AW'(1);
              state_r <= S_CAND;
            end
          end else if (CW'(j_r) + CW'(1) >= count_r) begin
            last_r <= 1'b1;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/kos_checker.sv */
// ----------------------------------------------------------------------------
// kos_checker
// Port-level checks for kth_order_select.
// ----------------------------------------------------------------------------
`include "kth_order_select_assert.svh"
module kos_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [1:0]                     out_tuser,
  input logic [kos_pkg::OUT_DATA_W-1:0] out_tdata
);
  import kos_pkg::*;

  logic err_out;
  assign err_out = out_tvalid && out_tuser != ST_OK && out_tuser != ST_RSV;

  `KOS_ASSERT_IMP(a_no_both, clk, rst_n, out_tvalid, !in_tready)
  `KOS_ASSERT_IMP(a_status_ok, clk, rst_n, out_tvalid, out_tuser != ST_RSV)
  `KOS_ASSERT_IMP(a_err_zero, clk, rst_n, err_out, out_tdata == '0)
  `KOS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind kth_order_select kos_checker u_kos_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
  .out_tdata(out_tdata)
);
